// File: sv/dv64_pkg.sv
// Shared types and constants for the pipelined 64-bit unsigned divider.
// No dependencies; used by unsigned_divider_64 and dv64_check.
package dv64_pkg;

	// Width of every numeric field on the ports.
	localparam int WORD_W = 64;

	// Default operand width that the datapath actually divides.
	localparam int DATA_WIDTH_DEF = 64;

	// Operands of one division.
	typedef struct packed {
		logic [WORD_W-1:0] dividend;
		logic [WORD_W-1:0] divisor;
	} op_t;

	// Result of one division.
	typedef struct packed {
		logic [WORD_W-1:0] quotient;
		logic [WORD_W-1:0] remainder;
		logic              divide_by_zero;
	} res_t;

endpackage

// File: sv/unsigned_divider_64.sv
// Top level of the pipelined restoring unsigned divider.
// Depends on dv64_pkg for the op_t / res_t word types and width constants.

// Unsigned restoring divider, fully pipelined: one stage per quotient bit.
// Each word on op carries a dividend and a divisor; only their low DATA_WIDTH
// bits are divided, higher bits are ignored. Each word on res carries the
// quotient and remainder, zero-extended to 64 bits. A zero divisor gives a
// quotient and remainder of 0 and sets divide_by_zero. Throughput is one
// division per clock while op_stall is low. The accepting edge loads stage 1;
// the word then passes through the remaining stages, each doing one
// compare-and-subtract of the DATA_WIDTH+1-bit partial remainder against the
// divisor, and then loads the output register. Behind the output register
// sits a one-word skid register; while a result waits in the output register
// the pipeline keeps advancing and keeps taking words, and only when the skid
// register also holds a result does the whole pipeline freeze and op_stall
// go high. op_stall is a register output and never depends combinationally
// on res_stall.
module unsigned_divider_64
	import dv64_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic op_valid,
	output logic op_stall,
	input  op_t  op,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	localparam int W = DATA_WIDTH;

	// Pipeline registers, index = stage number.
	// nq: remaining dividend bits at the top, finished quotient bits shifted in at the bottom.
	logic         vld_s [1:W];
	logic [W-1:0] nq_s  [1:W];
	logic [W-1:0] rem_s [1:W];
	logic [W-1:0] den_s [1:W];
	logic         dz_s  [1:W];

	// Output register and skid register.
	logic res_v_q;
	res_t res_q;
	logic skid_v_q;
	res_t skid_q;

	logic adv;       // pipeline advances this cycle
	logic out_free;  // output register can take a new word
	res_t fin;       // result formed from the last stage

	// Freeze the pipeline only while the skid register is occupied.
	assign adv      = !skid_v_q;
	assign op_stall = skid_v_q;
	assign out_free = !res_v_q || !res_stall;

	genvar k;
	generate
		for (k = 1; k <= W; k++) begin : g_stage
			logic         v_in;
			logic [W-1:0] nq_in;
			logic [W-1:0] rem_in;
			logic [W-1:0] den_in;
			logic         dz_in;
			logic [W:0]   trial;
			logic [W:0]   diff;
			logic         ge;

			if (k == 1) begin : g_first
				// Stage 1 works straight from the accepted operands.
				assign v_in   = op_valid;
				assign nq_in  = op.dividend[W-1:0];
				assign rem_in = '0;
				assign den_in = op.divisor[W-1:0];
				assign dz_in  = (op.divisor[W-1:0] == '0);
			end else begin : g_next
				assign v_in   = vld_s[k-1];
				assign nq_in  = nq_s[k-1];
				assign rem_in = rem_s[k-1];
				assign den_in = den_s[k-1];
				assign dz_in  = dz_s[k-1];
			end

			// Shift in the next dividend bit; subtract when the divisor fits.
			// The partial remainder stays below the divisor, so the trial value
			// is below twice the divisor and the top bit of the difference is
			// set exactly when the subtraction borrows.
			assign trial = {rem_in, nq_in[W-1]};
			assign diff  = trial - {1'b0, den_in};
			assign ge    = !diff[W];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else if (adv) begin
					vld_s[k] <= v_in;
				end
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					nq_s[k]  <= {nq_in[W-2:0], ge};
					rem_s[k] <= ge ? diff[W-1:0] : trial[W-1:0];
					den_s[k] <= den_in;
					dz_s[k]  <= dz_in;
				end
			end
		end
	endgenerate

	// Drop the datapath values when the divisor was zero.
	always_comb begin
		fin.quotient       = dz_s[W] ? '0 : WORD_W'(nq_s[W]);
		fin.remainder      = dz_s[W] ? '0 : WORD_W'(rem_s[W]);
		fin.divide_by_zero = dz_s[W];
	end

	// Output and skid control: drain skid first, else take the last stage;
	// park the last stage in skid when the output is held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			if (skid_v_q) begin
				res_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				res_v_q <= vld_s[W];
			end
		end else if (adv && vld_s[W]) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			res_q <= skid_v_q ? skid_q : fin;
		end else if (adv && vld_s[W]) begin
			skid_q <= fin;
		end
	end

	assign res_valid = res_v_q;
	assign res       = res_q;

endmodule

// File: sv/dv64_check.sv
// Port-level checker for unsigned_divider_64, attached by bind.
// Depends on dv64_pkg for the res_t word type.
module dv64_check
	import dv64_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic op_stall,
	input logic res_valid,
	input logic res_stall,
	input res_t res
);

	// A held result stays offered.
	a_res_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("res_valid dropped while stalled");

	// A held result does not change.
	a_res_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(res))
		else $error("res changed while stalled");

	// A zero divisor gives zero quotient and remainder.
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.divide_by_zero |-> res.quotient == '0 && res.remainder == '0)
		else $error("nonzero result with divide_by_zero");

	// Results never carry bits above the operand width.
	a_width: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.quotient >> DATA_WIDTH) == '0 && (res.remainder >> DATA_WIDTH) == '0)
		else $error("result bits above DATA_WIDTH");

	// Input back-pressure only follows a held output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(op_stall) |-> $past(res_valid && res_stall))
		else $error("op_stall rose without a held result");

endmodule

bind unsigned_divider_64 dv64_check #(.DATA_WIDTH(DATA_WIDTH)) u_dv64_check (.*);
